// ===== sv/mva_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI voice allocator package
// Shared types, constants and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mva_pkg;

  localparam int unsigned VoicesDef = 8;

  localparam int unsigned OwnerW = 5;
  localparam logic [OwnerW-1:0] FreeOwner = 5'd16;

  localparam logic [3:0] FuncNoteOn = 4'd9;

  localparam logic [1:0] ActNone  = 2'd0;
  localparam logic [1:0] ActStart = 2'd1;
  localparam logic [1:0] ActStop  = 2'd2;

  typedef struct packed {
    logic [3:0]  func;
    logic [3:0]  channel;
    logic [31:0] note;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  voice_index;
    logic [1:0]  action;
    logic [31:0] drive_freq;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/mva_ctrl.sv =====
// ----------------------------------------------------------------------------
// MIDI voice allocator controller
// Sequences capture, voice scan and commit; owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire mva_pkg::sts_t sts_i,
  output mva_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the result word
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mva_datapath.sv =====
// ----------------------------------------------------------------------------
// MIDI voice allocator datapath
// Voice table, one-voice-per-cycle scan, selection and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mva_datapath #(
  parameter int unsigned Voices = mva_pkg::VoicesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              poly_mode_i,
  input  wire mva_pkg::in_word_t in_data_i,
  input  wire mva_pkg::cmd_t     cmd_i,
  output mva_pkg::sts_t          sts_o,
  output mva_pkg::out_word_t     out_data_o
);

  localparam int unsigned IdxW = (Voices > 1) ? $clog2(Voices) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Voices - 1);

  logic [mva_pkg::OwnerW-1:0] owner_q [Voices];
  logic [31:0]                freq_q  [Voices];

  mva_pkg::in_word_t  item_q;
  mva_pkg::out_word_t out_q, out_d;
  logic [IdxW-1:0]    scan_idx_q;
  logic               free_hit_q, ch_hit_q, match_hit_q;
  logic [IdxW-1:0]    free_idx_q, ch_idx_q, match_idx_q;

  logic [mva_pkg::OwnerW-1:0] cur_owner;
  logic                       is_free, is_ch, is_match;
  logic                       note_on, sel_hit;
  logic [IdxW-1:0]            sel_idx;

  assign cur_owner = owner_q[scan_idx_q];
  assign is_free   = (cur_owner == mva_pkg::FreeOwner);
  assign is_ch     = (cur_owner == {1'b0, item_q.channel});
  assign is_match  = is_ch && (freq_q[scan_idx_q] == item_q.note);

  assign sts_o.scan_last = (scan_idx_q == LastIdx);

  assign note_on = (item_q.func == mva_pkg::FuncNoteOn);

  always_comb begin
    sel_hit = 1'b0;
    sel_idx = '0;
    if (note_on) begin
      if (poly_mode_i) begin
        if (free_hit_q) begin
          sel_hit = 1'b1;
          sel_idx = free_idx_q;
        end else if (ch_hit_q) begin
          sel_hit = 1'b1;
          sel_idx = ch_idx_q;
        end
      end else begin
        if (ch_hit_q) begin
          sel_hit = 1'b1;
          sel_idx = ch_idx_q;
        end else if (free_hit_q) begin
          sel_hit = 1'b1;
          sel_idx = free_idx_q;
        end
      end
    end else begin
      sel_hit = match_hit_q;
      sel_idx = match_idx_q;
    end
  end

  always_comb begin
    out_d        = '0;
    out_d.action = mva_pkg::ActNone;
    if (sel_hit) begin
      out_d.found       = 1'b1;
      out_d.voice_index = 3'(sel_idx);
      if (note_on) begin
        out_d.action     = mva_pkg::ActStart;
        out_d.drive_freq = item_q.note;
      end else begin
        out_d.action     = mva_pkg::ActStop;
      end
    end
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q  <= '0;
      free_hit_q  <= 1'b0;
      ch_hit_q    <= 1'b0;
      match_hit_q <= 1'b0;
    end else if (cmd_i.load) begin
      scan_idx_q  <= '0;
      free_hit_q  <= 1'b0;
      ch_hit_q    <= 1'b0;
      match_hit_q <= 1'b0;
    end else if (cmd_i.step) begin
      if (!sts_o.scan_last) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
      // keep only the first hit of each kind
      if (is_free && !free_hit_q) begin
        free_hit_q <= 1'b1;
      end
      if (is_ch && !ch_hit_q) begin
        ch_hit_q <= 1'b1;
      end
      if (is_match && !match_hit_q) begin
        match_hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.step) begin
      if (is_free && !free_hit_q) begin
        free_idx_q <= scan_idx_q;
      end
      if (is_ch && !ch_hit_q) begin
        ch_idx_q <= scan_idx_q;
      end
      if (is_match && !match_hit_q) begin
        match_idx_q <= scan_idx_q;
      end
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  // voice table: owner resets to free, freq only matters once owned
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Voices; i++) begin
        owner_q[i] <= mva_pkg::FreeOwner;
      end
    end else if (cmd_i.commit && sel_hit) begin
      owner_q[sel_idx] <= note_on ? {1'b0, item_q.channel} : mva_pkg::FreeOwner;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && sel_hit && note_on) begin
      freq_q[sel_idx] <= item_q.note;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== sv/midi_voice_allocator.sv =====
// ----------------------------------------------------------------------------
// MIDI voice allocator
// Assigns note-on/note-off words to a bank of voices, one word at a time.
// ----------------------------------------------------------------------------
//   channel  direction  payload            notes
//   in       sink       mva_pkg::in_word_t func, channel, note
//   out      source     mva_pkg::out_word_t found, voice_index, action, freq
//   cfg      sink       1 bit poly_mode    always ready, reset value 1
//
// An input word is captured when it is accepted; the table scan then visits one
// voice per cycle, and the commit writes the result register and the voice table.
// The next word is taken the cycle after the commit; the result of the last word
// may still wait in the output register. A stall on out holds the commit of the
// following word. After reset every voice is free; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_voice_allocator #(
  parameter int unsigned Voices = mva_pkg::VoicesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mva_pkg::in_word_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mva_pkg::out_word_t      out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_data_i
);

  mva_pkg::cmd_t cmd;
  mva_pkg::sts_t sts;
  logic          poly_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_mode_q <= 1'b1;
    end else if (cfg_valid_i) begin
      poly_mode_q <= cfg_data_i;
    end
  end

  mva_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mva_datapath #(
    .Voices (Voices)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .poly_mode_i (poly_mode_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_midi_voice_allocator.sv =====
// ----------------------------------------------------------------------------
// MIDI voice allocator testbench
// Sends note-on/note-off words and mode writes over valid/ready channels with
// random idling on both sides. A scoreboard keeps its own voice table and
// checks each result word against it, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_midi_voice_allocator;

  localparam int unsigned Latency    = mva_pkg::VoicesDef + 2;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned RandPerPhase = 176;
  localparam int unsigned HoldOffCycles = 300;

  // Voice table shadow: predicts one result word per accepted input word.
  class voice_scoreboard;
    logic [mva_pkg::OwnerW-1:0] owner [mva_pkg::VoicesDef];
    logic [31:0]                freq [mva_pkg::VoicesDef];
    bit                         poly_mode;
    mva_pkg::out_word_t         expected_q[$];
    int unsigned                errors;

    function new();
      poly_mode = 1'b1;
      errors = 0;
      for (int i = 0; i < mva_pkg::VoicesDef; i++) begin
        owner[i] = mva_pkg::FreeOwner;
        freq[i]  = '0;
      end
    endfunction

    function void note_event(mva_pkg::in_word_t w);
      int first_free;
      int first_same;
      int idx;
      logic [mva_pkg::OwnerW-1:0] ch;
      mva_pkg::out_word_t res;
      first_free = -1;
      first_same = -1;
      idx = -1;
      ch = {1'b0, w.channel};
      res = '0;
      if (w.func == mva_pkg::FuncNoteOn) begin
        for (int i = 0; i < mva_pkg::VoicesDef; i++) begin
          if (owner[i] == mva_pkg::FreeOwner && first_free < 0) first_free = i;
          if (owner[i] == ch && first_same < 0) first_same = i;
        end
        if (poly_mode) idx = (first_free >= 0) ? first_free : first_same;
        else idx = (first_same >= 0) ? first_same : first_free;
        if (idx >= 0) begin
          owner[idx] = ch;
          freq[idx] = w.note;
          res.found = 1'b1;
          res.voice_index = idx[2:0];
          res.action = mva_pkg::ActStart;
          res.drive_freq = w.note;
        end
      end else begin
        for (int i = 0; i < mva_pkg::VoicesDef; i++) begin
          if (idx < 0 && owner[i] == ch && freq[i] == w.note) idx = i;
        end
        // free the voice but keep its frequency
        if (idx >= 0) begin
          owner[idx] = mva_pkg::FreeOwner;
          res.found = 1'b1;
          res.voice_index = idx[2:0];
          res.action = mva_pkg::ActStop;
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(mva_pkg::out_word_t got);
      mva_pkg::out_word_t want;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: found=%0b voice_index=%0d action=%0d",
               got.found, got.voice_index, got.action);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, got.found);
        errors++;
      end
      if (got.voice_index !== want.voice_index) begin
        $error("voice_index: expected %0d, actual %0d", want.voice_index, got.voice_index);
        errors++;
      end
      if (got.action !== want.action) begin
        $error("action: expected %0d, actual %0d", want.action, got.action);
        errors++;
      end
      if (got.drive_freq !== want.drive_freq) begin
        $error("drive_freq: expected %0h, actual %0h", want.drive_freq, got.drive_freq);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  mva_pkg::in_word_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  mva_pkg::out_word_t out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_data_i = 1'b0;

  voice_scoreboard sb;
  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 51;
  int unsigned recv_hold = 0;
  int unsigned stall_cycles = 0;

  midi_voice_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitor and watchdog. Results are checked before the input of the same
  // edge is noted; the latency keeps them apart anyway.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (in_valid_i && in_ready_o) sb.note_event(in_data_i);
      if (cfg_valid_i && cfg_ready_o) sb.poly_mode = cfg_data_i;
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic mva_pkg::in_word_t make_word(logic [3:0] f, logic [3:0] c,
                                                  logic [31:0] n);
    mva_pkg::in_word_t w;
    w.func = f;
    w.channel = c;
    w.note = n;
    return w;
  endfunction

  function automatic logic [3:0] note_off_func();
    logic [3:0] f;
    f = 4'($urandom_range(14));
    if (f >= mva_pkg::FuncNoteOn) f = f + 4'd1;
    return f;
  endfunction

  function automatic logic [31:0] pick_note();
    // a small pool makes duplicate notes, so a note-off must pick the first
    if ($urandom_range(1) == 0) return 32'd440000 + 32'd1000 * $urandom_range(7);
    return $urandom;
  endfunction

  function automatic mva_pkg::in_word_t random_word();
    int unsigned r;
    int unsigned v;
    logic [3:0] ch;
    r = $urandom_range(99);
    ch = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
    if (r < 55) return make_word(mva_pkg::FuncNoteOn, ch, pick_note());
    if (r < 90) begin
      // release a note that a voice is playing now, if the picked voice is in use
      v = $urandom_range(mva_pkg::VoicesDef - 1);
      if (sb.owner[v] != mva_pkg::FreeOwner) begin
        return make_word(note_off_func(), sb.owner[v][3:0], sb.freq[v]);
      end
      return make_word(note_off_func(), ch, pick_note());
    end
    return make_word(4'($urandom_range(15)), 4'($urandom_range(15)), $urandom);
  endfunction

  task automatic send_word(mva_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, let the monitor note the last word, wait for every pending
  // result, then let the block settle.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic write_mode(logic poly);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= poly;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_directed();
    // poly mode from reset
    send_word(make_word(4'd8, 4'd0, 32'd0));                 // release on empty bank
    send_word(make_word(mva_pkg::FuncNoteOn, 4'd0, 32'd0));
    send_word(make_word(mva_pkg::FuncNoteOn, 4'd15, 32'hFFFF_FFFF));
    for (int i = 1; i <= 6; i++) begin
      send_word(make_word(mva_pkg::FuncNoteOn, 4'd3, 32'd1000 * i));
    end
    send_word(make_word(mva_pkg::FuncNoteOn, 4'd5, 32'd123));   // bank full, no owner
    send_word(make_word(mva_pkg::FuncNoteOn, 4'd15, 32'd5555)); // steal from own channel
    send_word(make_word(4'd0, 4'd15, 32'd5555));
    send_word(make_word(4'd0, 4'd15, 32'd5555));              // freed voice must not match
    send_word(make_word(4'd15, 4'd0, 32'd0));
    send_word(make_word(4'd10, 4'd3, 32'd999));               // wrong note
    settle_idle();
    write_mode(1'b0);
    send_word(make_word(mva_pkg::FuncNoteOn, 4'd3, 32'd7000));  // reuse own channel first
    send_word(make_word(mva_pkg::FuncNoteOn, 4'd7, 32'd7777));
    send_word(make_word(mva_pkg::FuncNoteOn, 4'd9, 32'd8888));
    send_word(make_word(mva_pkg::FuncNoteOn, 4'd12, 32'd1));    // nothing available
    send_word(make_word(4'd8, 4'd3, 32'd2000));
    send_word(make_word(mva_pkg::FuncNoteOn, 4'd4, 32'hA5A5_A5A5));
    settle_idle();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 51;
          write_mode(1'b1);
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 13;
          write_mode(1'b0);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_mode(1'b1);
          // hold the output off so the block backs up into its input
          recv_hold = HoldOffCycles;
        end
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        send_word(random_word());
        if (phase == 0 && n == RandPerPhase / 2) settle_idle();
      end
      settle_idle();
    end
    repeat (3 * Latency) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
